[hw/rtl/lfbe_pkg.sv]
`default_nettype none
package lfbe_pkg;

    // Field widths of the command and pixel words
    localparam int OP_W      = 3;
    localparam int IDX_W     = 6;
    localparam int CH_W      = 8;
    localparam int HUE_OFF_W = 16;
    localparam int LEN_W     = 7;
    localparam int PIX_W     = 3 * CH_W;

    localparam int DEF_MAX_PIXELS = 64;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    // Hue arithmetic: a full turn, one sector, and the width that holds a hue
    localparam int HUE_W = 9;
    localparam logic [HUE_W-1:0] HUE_RANGE = 9'd360;
    localparam logic [HUE_W-1:0] HUE_SECTOR = 9'd60;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SET     = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_FILL    = 3'd2,
        OP_RAINBOW = 3'd3,
        OP_FADE    = 3'd4,
        OP_SHOW    = 3'd5
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [IDX_W-1:0]     idx;
        logic [CH_W-1:0]      red;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      blue;
        logic [HUE_OFF_W-1:0] hue_offset;
        logic [CH_W-1:0]      fade_amount;
    } t_cmd;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_FILL,
        BS_DIV,
        BS_HUE,
        BS_RBW,
        BS_FRD,
        BS_FWR,
        BS_SRD,
        BS_SOUT
    } t_bstate;

endpackage
`default_nettype wire

[hw/rtl/lfbe_if.sv]
`default_nettype none
interface lfbe_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [lfbe_pkg::OP_W-1:0]       op;
    logic [lfbe_pkg::IDX_W-1:0]      pixel_index;
    logic [lfbe_pkg::CH_W-1:0]       red_in;
    logic [lfbe_pkg::CH_W-1:0]       green_in;
    logic [lfbe_pkg::CH_W-1:0]       blue_in;
    logic [lfbe_pkg::HUE_OFF_W-1:0]  hue_offset;
    logic [lfbe_pkg::CH_W-1:0]       fade_amount;

    modport source(output valid, op, pixel_index, red_in, green_in, blue_in,
                   hue_offset, fade_amount, input ready);
    modport sink(input valid, op, pixel_index, red_in, green_in, blue_in,
                 hue_offset, fade_amount, output ready);
endinterface

interface lfbe_pix_if;
    logic                        valid;
    logic                        ready;
    logic [lfbe_pkg::IDX_W-1:0]  frame_index;
    logic [lfbe_pkg::CH_W-1:0]   red_out;
    logic [lfbe_pkg::CH_W-1:0]   green_out;
    logic [lfbe_pkg::CH_W-1:0]   blue_out;
    logic                        frame_last;

    modport source(output valid, frame_index, red_out, green_out, blue_out,
                   frame_last, input ready);
    modport sink(input valid, frame_index, red_out, green_out, blue_out,
                 frame_last, output ready);
endinterface
`default_nettype wire

[hw/rtl/lfbe_front.sv]
`default_nettype none
module lfbe_front #(
    parameter int MAX_PIXELS = lfbe_pkg::DEF_MAX_PIXELS,
    localparam int CW = $clog2(MAX_PIXELS + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    lfbe_cmd_if.sink                        i_cmd,
    input  wire logic                       i_cfg_we,
    input  wire logic [lfbe_pkg::LEN_W-1:0] i_cfg_wdata,
    input  wire logic                       i_q_full,
    output logic                            o_push,
    output lfbe_pkg::t_cmd                  o_cmd,
    output logic [CW-1:0]                   o_len
);
    import lfbe_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic             keep;

    // Hold the strip length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    // Clamp the length into 1 .. MAX_PIXELS
    always_comb begin
        if (r_len == '0) begin
            o_len = CW'(1);
        end else if (r_len > LEN_W'(MAX_PIXELS)) begin
            o_len = CW'(MAX_PIXELS);
        end else begin
            o_len = r_len[CW-1:0];
        end
    end

    // Drop unused codes and sets beyond the strip
    always_comb begin
        unique case (i_cmd.op)
            OP_SET:     keep = LEN_W'(i_cmd.pixel_index) < LEN_W'(o_len);
            OP_CLEAR,
            OP_FILL,
            OP_RAINBOW,
            OP_FADE,
            OP_SHOW:    keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign i_cmd.ready = !i_q_full;
    assign o_push      = i_cmd.valid && !i_q_full && keep;

    always_comb begin
        o_cmd.op          = t_op'(i_cmd.op);
        o_cmd.idx         = i_cmd.pixel_index;
        o_cmd.red         = i_cmd.red_in;
        o_cmd.green       = i_cmd.green_in;
        o_cmd.blue        = i_cmd.blue_in;
        o_cmd.hue_offset  = i_cmd.hue_offset;
        o_cmd.fade_amount = i_cmd.fade_amount;
    end

    a_set_in_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.op == OP_SET) |-> (LEN_W'(o_cmd.idx) < LEN_W'(o_len)))
        else $error("set word queued for a pixel beyond the strip");

endmodule
`default_nettype wire

[hw/rtl/lfbe_queue.sv]
`default_nettype none
module lfbe_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  lfbe_pkg::t_cmd      i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output lfbe_pkg::t_cmd      o_data
);
    import lfbe_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_count;

    assign o_full  = r_count == NW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_slot[r_rp];

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + NW'(i_push) - NW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue popped while empty");

endmodule
`default_nettype wire

[hw/rtl/lfbe_back.sv]
`default_nettype none
module lfbe_back #(
    parameter int MAX_PIXELS = lfbe_pkg::DEF_MAX_PIXELS,
    localparam int CW = $clog2(MAX_PIXELS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  lfbe_pkg::t_cmd     i_q_cmd,
    output logic               o_pop,
    input  wire logic [CW-1:0] i_len,
    lfbe_pix_if.source         o_pix
);
    import lfbe_pkg::*;

    localparam int IW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SW = $clog2(HUE_W);
    localparam int OW = HUE_OFF_W + 1;
    localparam logic [CW-1:0] LAST_ADDR = CW'(MAX_PIXELS - 1);
    localparam logic [OW-1:0] OFF_BASE  = OW'(HUE_RANGE);

    // Turn a hue below a full turn into a colour at full saturation and value
    function automatic logic [PIX_W-1:0] hue_rgb(input logic [HUE_W-1:0] h);
        logic [2:0]      sec;
        logic [HUE_W-1:0] base;
        logic [5:0]      e;
        logic [9:0]      tf;
        logic [9:0]      qf;
        logic [CH_W-1:0] t;
        logic [CH_W-1:0] q;
        logic [PIX_W-1:0] rgb;
        priority if (h >= HUE_W'(5 * HUE_SECTOR)) begin
            sec = 3'd5; base = HUE_W'(5 * HUE_SECTOR);
        end else if (h >= HUE_W'(4 * HUE_SECTOR)) begin
            sec = 3'd4; base = HUE_W'(4 * HUE_SECTOR);
        end else if (h >= HUE_W'(3 * HUE_SECTOR)) begin
            sec = 3'd3; base = HUE_W'(3 * HUE_SECTOR);
        end else if (h >= HUE_W'(2 * HUE_SECTOR)) begin
            sec = 3'd2; base = HUE_W'(2 * HUE_SECTOR);
        end else if (h >= HUE_SECTOR) begin
            sec = 3'd1; base = HUE_SECTOR;
        end else begin
            sec = 3'd0; base = '0;
        end
        e  = 6'(h - base);
        // 255/60 is exactly 17/4
        tf = 10'(e) * 10'd17;
        qf = 10'(6'd60 - e) * 10'd17;
        t  = tf[9:2];
        q  = qf[9:2];
        unique case (sec)
            3'd0:    rgb = {8'hFF, t, 8'h00};
            3'd1:    rgb = {q, 8'hFF, 8'h00};
            3'd2:    rgb = {8'h00, 8'hFF, t};
            3'd3:    rgb = {8'h00, q, 8'hFF};
            3'd4:    rgb = {t, 8'h00, 8'hFF};
            default: rgb = {8'hFF, 8'h00, q};
        endcase
        return rgb;
    endfunction

    function automatic logic [CH_W-1:0] sat_sub(input logic [CH_W-1:0] v,
                                                 input logic [CH_W-1:0] a);
        return (v > a) ? v - a : '0;
    endfunction

    t_bstate          r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [SW-1:0]    r_step, n_step;
    logic [CW-1:0]    r_rem, n_rem;
    logic [HUE_W-1:0] r_divq, n_divq;
    logic [OW-1:0]    r_off, n_off;
    logic [HUE_W-1:0] r_accq, n_accq;
    logic [CW-1:0]    r_accr, n_accr;
    logic [HUE_W-1:0] r_hue, n_hue;

    logic [PIX_W-1:0] r_mem [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] r_vld;
    logic [PIX_W-1:0] r_rd_data;
    logic             r_rd_vld;

    logic             mem_we, rd_en, clear_all;
    logic [IW-1:0]    mem_wa, rd_a;
    logic [PIX_W-1:0] mem_wd, pix_rd;
    logic [CW-1:0]    cnt_inc, len_m1;
    logic             frame_last;
    logic [CW:0]      trial, racc;
    logic             trial_ge, racc_ge;
    logic [OW-1:0]    off_cmp;
    logic [HUE_W:0]   hsum;

    assign pix_rd     = r_rd_vld ? r_rd_data : '0;
    assign cnt_inc    = r_cnt + 1'b1;
    assign len_m1     = i_len - 1'b1;
    assign frame_last = r_cnt == len_m1;
    assign trial      = {r_rem, HUE_RANGE[r_step]};
    assign trial_ge   = trial >= {1'b0, i_len};
    assign off_cmp    = OFF_BASE << r_step;
    assign racc       = {1'b0, r_accr} + {1'b0, r_rem};
    assign racc_ge    = racc >= {1'b0, i_len};
    assign hsum       = {1'b0, r_accq} + {1'b0, r_off[HUE_W-1:0]};

    // Step the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op)
                        OP_FILL:    n_state = BS_FILL;
                        OP_RAINBOW: n_state = BS_DIV;
                        OP_FADE:    n_state = BS_FRD;
                        OP_SHOW:    n_state = BS_SRD;
                        default:    n_state = BS_IDLE;
                    endcase
                end
            end
            BS_FILL: if (r_cnt == LAST_ADDR) n_state = BS_SRD;
            BS_DIV:  if (r_step == '0) n_state = BS_HUE;
            BS_HUE:  n_state = BS_RBW;
            BS_RBW:  n_state = frame_last ? BS_SRD : BS_HUE;
            BS_FRD:  n_state = BS_FWR;
            BS_FWR:  n_state = (r_cnt == LAST_ADDR) ? BS_SRD : BS_FRD;
            BS_SRD:  n_state = BS_SOUT;
            BS_SOUT: if (o_pix.ready && frame_last) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    // Drive the store ports and the datapath registers
    always_comb begin
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_wa    = r_cnt[IW-1:0];
        mem_wd    = '0;
        rd_en     = 1'b0;
        rd_a      = r_cnt[IW-1:0];
        clear_all = 1'b0;
        n_cmd     = r_cmd;
        n_cnt     = r_cnt;
        n_step    = r_step;
        n_rem     = r_rem;
        n_divq    = r_divq;
        n_off     = r_off;
        n_accq    = r_accq;
        n_accr    = r_accr;
        n_hue     = r_hue;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_q_cmd;
                    n_cnt  = '0;
                    n_step = SW'(HUE_W - 1);
                    n_rem  = '0;
                    n_divq = '0;
                    n_off  = OW'(i_q_cmd.hue_offset);
                    unique case (i_q_cmd.op)
                        OP_SET: begin
                            mem_we = 1'b1;
                            mem_wa = i_q_cmd.idx[IW-1:0];
                            mem_wd = {i_q_cmd.red, i_q_cmd.green, i_q_cmd.blue};
                        end
                        OP_CLEAR: clear_all = 1'b1;
                        default:  ;
                    endcase
                end
            end
            BS_FILL: begin
                mem_we = 1'b1;
                mem_wd = {r_cmd.red, r_cmd.green, r_cmd.blue};
                n_cnt  = (r_cnt == LAST_ADDR) ? '0 : cnt_inc;
            end
            BS_DIV: begin
                // One quotient bit of 360 / length and one offset reduction
                n_rem  = trial_ge ? CW'(trial - {1'b0, i_len}) : trial[CW-1:0];
                n_divq = {r_divq[HUE_W-2:0], trial_ge};
                n_off  = (r_off >= off_cmp) ? r_off - off_cmp : r_off;
                n_step = r_step - 1'b1;
                n_accq = '0;
                n_accr = '0;
            end
            BS_HUE: begin
                n_hue = (hsum >= {1'b0, HUE_RANGE}) ? HUE_W'(hsum - {1'b0, HUE_RANGE})
                                                    : hsum[HUE_W-1:0];
            end
            BS_RBW: begin
                mem_we = 1'b1;
                mem_wd = hue_rgb(r_hue);
                // Advance i*360/length by quotient and remainder
                n_accr = racc_ge ? CW'(racc - {1'b0, i_len}) : racc[CW-1:0];
                n_accq = r_accq + r_divq + HUE_W'(racc_ge);
                n_cnt  = frame_last ? '0 : cnt_inc;
            end
            BS_FRD: rd_en = 1'b1;
            BS_FWR: begin
                mem_we = 1'b1;
                mem_wd = {sat_sub(pix_rd[23:16], r_cmd.fade_amount),
                          sat_sub(pix_rd[15:8], r_cmd.fade_amount),
                          sat_sub(pix_rd[7:0], r_cmd.fade_amount)};
                n_cnt  = (r_cnt == LAST_ADDR) ? '0 : cnt_inc;
            end
            BS_SRD: rd_en = 1'b1;
            BS_SOUT: begin
                // Fetch the next pixel as this one is taken
                if (o_pix.ready && !frame_last) begin
                    rd_en = 1'b1;
                    rd_a  = cnt_inc[IW-1:0];
                    n_cnt = cnt_inc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_step <= n_step;
        r_rem  <= n_rem;
        r_divq <= n_divq;
        r_off  <= n_off;
        r_accq <= n_accq;
        r_accr <= n_accr;
        r_hue  <= n_hue;
    end

    // Pixel store with a registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_a];
        end
    end

    // Mark written entries; an unmarked entry reads as black
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (clear_all) begin
                r_vld <= '0;
            end else if (mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_a];
            end
        end
    end

    assign o_pix.valid       = r_state == BS_SOUT;
    assign o_pix.frame_index = IDX_W'(r_cnt);
    assign o_pix.red_out     = pix_rd[23:16];
    assign o_pix.green_out   = pix_rd[15:8];
    assign o_pix.blue_out    = pix_rd[7:0];
    assign o_pix.frame_last  = frame_last;

    a_index_in_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (r_cnt < i_len))
        else $error("streamed pixel beyond the strip");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.ready && o_pix.frame_last) |=> (r_state == BS_IDLE))
        else $error("stream went on past the last pixel");

endmodule
`default_nettype wire

[hw/rtl/led_frame_buffer_engine_core.sv]
`default_nettype none
// RGB frame buffer for an LED strip of up to MAX_PIXELS pixels. Command words
// enter through a two-word queue, so a new word is taken while the engine is
// still busy or a pixel waits on the output. Set and clear finish as their
// word leaves the queue. Once it has, fill sweeps the whole store at one write
// a cycle, fade reads and writes back every entry, and rainbow runs bit-serial
// division of 360 by the length, then writes a hue colour to each pixel in the
// strip. Fill, rainbow, fade and show then stream the first strip_length pixels
// at one per cycle after a first read of the store, as long as the receiver
// takes them. The registered read of the store is why fade reads and writes
// each entry in separate states, and why the stream needs its first read ahead.
// Reset black-out is by per-entry valid bits, so there is no clearing pass.
// Write strip_length only while idle.
module led_frame_buffer_engine_core #(
    parameter int MAX_PIXELS = lfbe_pkg::DEF_MAX_PIXELS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    lfbe_cmd_if.sink                        i_cmd,
    lfbe_pix_if.source                      o_pix,
    input  wire logic                       i_cfg_we,
    input  wire logic [lfbe_pkg::LEN_W-1:0] i_cfg_wdata
);
    import lfbe_pkg::*;

    localparam int CW = $clog2(MAX_PIXELS + 1);

    logic          push, full, q_valid, pop;
    t_cmd          push_cmd, q_cmd;
    logic [CW-1:0] len;

    lfbe_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (full),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_len       (len)
    );

    lfbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    lfbe_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .i_len     (len),
        .o_pix     (o_pix)
    );

endmodule
`default_nettype wire
